>>> rtl/lfbc_pkg.sv
// Shared types and constants for the log-structured FIFO block cache.
package lfbc_pkg;

    localparam int KEY_IN_W   = 48;
    localparam int SLOT_OUT_W = 6;
    localparam int OCC_W      = 7;
    localparam int EVT_W      = 32;
    localparam int BYTES_W    = 64;
    localparam int BS_W       = 21;

    localparam logic [BS_W-1:0] BS_RESET = 21'd4096;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

endpackage

>>> rtl/log_fifo_block_cache.sv
// Log-structured FIFO block cache: ring of key slots scanned by one shared compare unit.
//
// Usage:
//   Items (operation, key) come in on item_valid / item_stall; one result per
//   item leaves on result_valid / result_stall. A transfer happens at a rising
//   edge with valid high and stall low. block_size is written on cfg_valid /
//   cfg_ready; the user must write it only while the block is idle, as the
//   block itself does not enforce this.
//   Every item reads the whole slot memory once, one entry per cycle, through
//   a single key comparator: a scan over all slots, then a step to drop an
//   older copy of the key (insert of a held key not at the write position),
//   a step to write the key (insert), and a step to load the result. The
//   block goes back to idle before the next item is taken.
//   After reset the block runs a clearing pass over the slot memory, with
//   item_stall high; configuration writes are taken meanwhile.
//   The result sits in an output register: the next item is accepted while it
//   waits, and a finished item holds in its last step while result_stall is
//   high and the output register is still full.
module log_fifo_block_cache #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfbc_pkg::BS_W-1:0]         block_size,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  lfbc_pkg::op_t                     operation,
    input  logic [lfbc_pkg::KEY_IN_W-1:0]     key,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              hit,
    output logic [lfbc_pkg::SLOT_OUT_W-1:0]   slot,
    output logic                              evicted,
    output logic [lfbc_pkg::KEY_IN_W-1:0]     evicted_key,
    output logic [lfbc_pkg::OCC_W-1:0]        occupancy,
    output logic                              full_res,
    output logic [lfbc_pkg::EVT_W-1:0]        evicted_total,
    output logic [lfbc_pkg::BYTES_W-1:0]      bytes_written
);
    import lfbc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_INVAL,
        S_WRITE,
        S_DONE
    } state_t;

    typedef logic [KEY_BITS:0] entry_t;

    state_t                 state_reg, state_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [SW-1:0]          wp_reg, wp_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [EVT_W-1:0]       ev_total_reg, ev_total_next;
    logic [BYTES_W-1:0]     byte_total_reg, byte_total_next;
    logic [BS_W-1:0]        bs_reg, bs_next;
    op_t                    op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   found_reg, found_next;
    logic [SW-1:0]          found_idx_reg, found_idx_next;
    logic                   wp_valid_reg, wp_valid_next;
    logic [KEY_BITS-1:0]    wp_key_reg, wp_key_next;
    logic                   ev_reg, ev_next;
    logic [SW-1:0]          res_slot_reg, res_slot_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic [SLOT_OUT_W-1:0]  slot_reg, slot_next;
    logic                   evd_reg, evd_next;
    logic [KEY_IN_W-1:0]    evk_reg, evk_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic                   full_reg, full_next;
    logic [EVT_W-1:0]       evt_reg, evt_next;
    logic [BYTES_W-1:0]     bytes_reg, bytes_next;

    entry_t                 mem [SLOTS];
    entry_t                 rd_data_reg;
    logic [SW-1:0]          rd_addr;
    logic                   wr_en;
    logic [SW-1:0]          wr_addr;
    entry_t                 wr_data;

    logic                   match;
    logic                   wp_hit_copy;
    logic                   ev_now;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign match       = rd_data_reg[KEY_BITS] && (rd_data_reg[KEY_BITS-1:0] == key_reg);
    assign wp_hit_copy = found_reg && (found_idx_reg == wp_reg);
    assign ev_now      = wp_valid_reg && !wp_hit_copy;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        ev_total_next   = ev_total_reg;
        byte_total_next = byte_total_reg;
        bs_next         = bs_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        wp_valid_next   = wp_valid_reg;
        wp_key_next     = wp_key_reg;
        ev_next         = ev_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && result_stall;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        evd_next        = evd_reg;
        evk_next        = evk_reg;
        occ_next        = occ_reg;
        full_next       = full_reg;
        evt_next        = evt_reg;
        bytes_next      = bytes_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;

        if (cfg_valid)
        begin
            bs_next = block_size;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next        = operation;
                    key_next       = KEY_BITS'(key);
                    found_next     = 1'b0;
                    found_idx_next = '0;
                    wp_valid_next  = 1'b0;
                    ev_next        = 1'b0;
                    idx_next       = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                if (match && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = idx_reg;
                end
                if (idx_reg == wp_reg)
                begin
                    wp_valid_next = rd_data_reg[KEY_BITS];
                    wp_key_next   = rd_data_reg[KEY_BITS-1:0];
                end
                if (idx_reg == LAST)
                begin
                    idx_next = '0;
                    if (op_reg == OP_LOOKUP)
                    begin
                        res_slot_next = found_next ? found_idx_next : '0;
                        state_next    = S_DONE;
                    end
                    else if (found_next && (found_idx_next != wp_reg))
                    begin
                        state_next = S_INVAL;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_INVAL:
            begin
                wr_en      = 1'b1;
                wr_addr    = found_idx_reg;
                wr_data    = '0;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                wr_en           = 1'b1;
                wr_addr         = wp_reg;
                wr_data         = {1'b1, key_reg};
                ev_next         = ev_now;
                count_next      = count_reg + 1'b1 - CW'(found_reg) - CW'(ev_now);
                ev_total_next   = ev_total_reg + EVT_W'(ev_now);
                byte_total_next = byte_total_reg + BYTES_W'(bs_reg);
                res_slot_next   = wp_reg;
                wp_next         = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    slot_next      = SLOT_OUT_W'(res_slot_reg);
                    evd_next       = ev_reg;
                    evk_next       = ev_reg ? KEY_IN_W'(wp_key_reg) : '0;
                    occ_next       = OCC_W'(count_reg);
                    full_next      = (count_reg == FULL_COUNT);
                    evt_next       = ev_total_reg;
                    bytes_next     = byte_total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            ev_total_reg   <= '0;
            byte_total_reg <= '0;
            bs_reg         <= BS_RESET;
            found_reg      <= 1'b0;
            ev_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            found_idx_reg  <= '0;
            wp_valid_reg   <= 1'b0;
            wp_key_reg     <= '0;
            res_slot_reg   <= '0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            evd_reg        <= 1'b0;
            evk_reg        <= '0;
            occ_reg        <= '0;
            full_reg       <= 1'b0;
            evt_reg        <= '0;
            bytes_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            ev_total_reg   <= ev_total_next;
            byte_total_reg <= byte_total_next;
            bs_reg         <= bs_next;
            found_reg      <= found_next;
            ev_reg         <= ev_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            found_idx_reg  <= found_idx_next;
            wp_valid_reg   <= wp_valid_next;
            wp_key_reg     <= wp_key_next;
            res_slot_reg   <= res_slot_next;
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
            evd_reg        <= evd_next;
            evk_reg        <= evk_next;
            occ_reg        <= occ_next;
            full_reg       <= full_next;
            evt_reg        <= evt_next;
            bytes_reg      <= bytes_next;
        end
    end

    assign cfg_ready     = 1'b1;
    assign item_stall    = (state_reg != S_IDLE);
    assign result_valid  = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evd_reg;
    assign evicted_key   = evk_reg;
    assign occupancy     = occ_reg;
    assign full_res      = full_reg;
    assign evicted_total = evt_reg;
    assign bytes_written = bytes_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("occupancy above slot count");

    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=>
            (wp_reg == (($past(wp_reg) == LAST) ? '0 : $past(wp_reg) + 1'b1)))
        else $error("write position did not advance after insert");

    a_lookup_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && op_reg == OP_LOOKUP) |=>
            ($stable(count_reg) && $stable(wp_reg) && $stable(byte_total_reg)))
        else $error("lookup changed cache state");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_IDLE) |-> !wr_en)
        else $error("slot memory written during scan");

endmodule

>>> sim/lfbc_result_checker.sv
`timescale 1ns / 1ps
// Checker for the log FIFO block cache: tracks the slot ring and compares every result transfer.
module lfbc_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [lfbc_pkg::BS_W-1:0]         block_size,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  lfbc_pkg::op_t                     operation,
    input  logic [lfbc_pkg::KEY_IN_W-1:0]     key,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic                              hit,
    input  logic [lfbc_pkg::SLOT_OUT_W-1:0]   slot,
    input  logic                              evicted,
    input  logic [lfbc_pkg::KEY_IN_W-1:0]     evicted_key,
    input  logic [lfbc_pkg::OCC_W-1:0]        occupancy,
    input  logic                              full_res,
    input  logic [lfbc_pkg::EVT_W-1:0]        evicted_total,
    input  logic [lfbc_pkg::BYTES_W-1:0]      bytes_written,
    output int                                mismatches,
    output int                                pending
);
    import lfbc_pkg::*;

    localparam int RING = 64;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [KEY_IN_W-1:0]   evicted_key;
        logic [OCC_W-1:0]      occupancy;
        logic                  full_res;
        logic [EVT_W-1:0]      evicted_total;
        logic [BYTES_W-1:0]    bytes_written;
    } cache_result_t;

    logic [KEY_IN_W-1:0]   ring_key [RING];
    logic                  ring_valid [RING];
    logic [SLOT_OUT_W-1:0] write_pos;
    logic [OCC_W-1:0]      held_count;
    logic [EVT_W-1:0]      evict_count;
    logic [BYTES_W-1:0]    byte_count;
    logic [BS_W-1:0]       cur_block_size;
    int                    errors = 0;

    cache_result_t awaited_results [$];

    function automatic cache_result_t apply_cache_item(op_t op, logic [KEY_IN_W-1:0] k);
        cache_result_t r;
        int            found;
        found = -1;
        r     = '0;
        for (int i = 0; i < RING; i++)
        begin
            if (found < 0 && ring_valid[i] && ring_key[i] == k)
                found = i;
        end
        r.hit = (found >= 0);
        if (op == OP_LOOKUP)
        begin
            if (found >= 0)
                r.slot = found[SLOT_OUT_W-1:0];
        end
        else
        begin
            // drop the older copy first; a copy at the write position is then no eviction
            if (found >= 0)
            begin
                ring_valid[found] = 1'b0;
                held_count        = held_count - 1'b1;
            end
            if (ring_valid[write_pos])
            begin
                r.evicted     = 1'b1;
                r.evicted_key = ring_key[write_pos];
                held_count    = held_count - 1'b1;
                evict_count   = evict_count + 1'b1;
            end
            ring_key[write_pos]   = k;
            ring_valid[write_pos] = 1'b1;
            held_count            = held_count + 1'b1;
            r.slot                = write_pos;
            write_pos             = write_pos + 1'b1;
            byte_count            = byte_count + cur_block_size;
        end
        r.occupancy     = held_count;
        r.full_res      = (held_count == RING);
        r.evicted_total = evict_count;
        r.bytes_written = byte_count;
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cache_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RING; i++)
                ring_valid[i] = 1'b0;
            write_pos      = '0;
            held_count     = '0;
            evict_count    = '0;
            byte_count     = '0;
            cur_block_size = BS_RESET;
            awaited_results.delete();
            pending    <= 0;
            mismatches <= errors;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cur_block_size = block_size;
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("hit", 64'(want.hit), 64'(hit));
                    compare_field("slot", 64'(want.slot), 64'(slot));
                    compare_field("evicted", 64'(want.evicted), 64'(evicted));
                    compare_field("evicted_key", 64'(want.evicted_key), 64'(evicted_key));
                    compare_field("occupancy", 64'(want.occupancy), 64'(occupancy));
                    compare_field("full_res", 64'(want.full_res), 64'(full_res));
                    compare_field("evicted_total", 64'(want.evicted_total),
                                  64'(evicted_total));
                    compare_field("bytes_written", want.bytes_written, bytes_written);
                end
            end
            if (item_valid && !item_stall)
                awaited_results.push_back(apply_cache_item(operation, key));
            pending    <= awaited_results.size();
            mismatches <= errors;
        end
    end

endmodule

>>> sim/log_fifo_block_cache_tb.sv
`timescale 1ns / 1ps
// Testbench top for the log FIFO block cache: stimulus, idling, verdict.
module log_fifo_block_cache_tb;
    import lfbc_pkg::*;

    localparam int POOL   = 80;
    localparam int PHASES = 8;
    localparam int PER_PHASE = 192;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [BS_W-1:0]       block_size   = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    op_t                   operation    = OP_INSERT;
    logic [KEY_IN_W-1:0]   key          = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [KEY_IN_W-1:0]   evicted_key;
    logic [OCC_W-1:0]      occupancy;
    logic                  full_res;
    logic [EVT_W-1:0]      evicted_total;
    logic [BYTES_W-1:0]    bytes_written;

    int                    mismatches;
    int                    pending;
    logic                  quiet = 1'b0;
    int                    stall_hold = 0;
    int                    stall_pick;
    logic [KEY_IN_W-1:0]   key_pool [POOL];

    log_fifo_block_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .block_size    (block_size),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .key           (key),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .hit           (hit),
        .slot          (slot),
        .evicted       (evicted),
        .evicted_key   (evicted_key),
        .occupancy     (occupancy),
        .full_res      (full_res),
        .evicted_total (evicted_total),
        .bytes_written (bytes_written)
    );

    lfbc_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .block_size    (block_size),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .key           (key),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .hit           (hit),
        .slot          (slot),
        .evicted       (evicted),
        .evicted_key   (evicted_key),
        .occupancy     (occupancy),
        .full_res      (full_res),
        .evicted_total (evicted_total),
        .bytes_written (bytes_written),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("log_fifo_block_cache: mismatch");
        $finish;
    end

    // receiver back-pressure: mostly short runs, now and then a long stall
    always @(posedge clk)
    begin
        if (quiet)
            result_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55)
            begin
                result_stall <= 1'b0;
                stall_hold   <= $urandom_range(0, 3);
            end
            else if (stall_pick < 95)
            begin
                result_stall <= 1'b1;
                stall_hold   <= $urandom_range(0, 4);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_hold   <= $urandom_range(20, 150);
            end
        end
    end

    function automatic logic [KEY_IN_W-1:0] random_key();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KEY_IN_W-1:0];
    endfunction

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 4);
        else if (pick < 97)
            return $urandom_range(5, 70);
        return $urandom_range(70, 200);
    endfunction

    function automatic logic [BS_W-1:0] phase_block_size(int phase);
        case (phase)
            0:       return 21'd0;
            1:       return 21'd1;
            2:       return 21'd1048576;
            3:       return 21'h1FFFFF;
            5:       return BS_RESET;
            7:       return 21'd1048575;
            default: return BS_W'($urandom_range(1, 1048576));
        endcase
    endfunction

    // valid stays high across back-to-back items; only the payload moves
    task automatic send_item(op_t op, logic [KEY_IN_W-1:0] k, int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        key        <= k;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_block_size(logic [BS_W-1:0] v);
        cfg_valid  <= 1'b1;
        block_size <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
    endtask

    initial
    begin
        logic [KEY_IN_W-1:0] k;
        op_t                 op;
        int                  rr;
        int                  style;
        rr = 0;
        for (int i = 0; i < POOL; i++)
            key_pool[i] = random_key();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_block_size(21'd1);
        send_item(OP_LOOKUP, 48'h0, sender_gap());                // empty cache miss
        send_item(OP_INSERT, 48'h0, sender_gap());
        send_item(OP_INSERT, 48'hFFFF_FFFF_FFFF, sender_gap());
        send_item(OP_INSERT, 48'h5555_5555_5555, sender_gap());
        send_item(OP_INSERT, 48'hAAAA_AAAA_AAAA, sender_gap());
        send_item(OP_LOOKUP, 48'h0, sender_gap());
        send_item(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, sender_gap());
        send_item(OP_LOOKUP, 48'h0000_0012_3456, sender_gap());
        send_item(OP_INSERT, 48'h0, sender_gap());                // rewrite of a held key
        send_item(OP_LOOKUP, 48'h0, sender_gap());
        send_item(OP_INSERT, 48'hFFFF_FFFF_FFFF, sender_gap());
        send_item(OP_LOOKUP, 48'h5555_5555_5555, sender_gap());
        send_item(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, sender_gap());
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet <= (phase % 4 == 3);
            write_block_size(phase_block_size(phase));
            style = phase % 3;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                case (style)
                    0:
                    begin
                        op = ($urandom_range(0, 99) < 65) ? OP_INSERT : OP_LOOKUP;
                        k  = key_pool[$urandom_range(0, POOL - 1)];
                    end
                    1:
                    begin
                        // round robin over exactly one ring of keys: rewrites land on
                        // the write position
                        if ($urandom_range(0, 99) < 85)
                        begin
                            op = OP_INSERT;
                            k  = key_pool[rr % 64];
                            rr++;
                        end
                        else
                        begin
                            op = OP_LOOKUP;
                            k  = key_pool[$urandom_range(0, 63)];
                        end
                    end
                    default:
                    begin
                        op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_LOOKUP;
                        k  = ($urandom_range(0, 1) == 0) ? random_key()
                                                         : key_pool[$urandom_range(0, POOL - 1)];
                    end
                endcase
                send_item(op, k, sender_gap());
            end
            drain();
        end

        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("log_fifo_block_cache: match");
        else
            $display("log_fifo_block_cache: mismatch");
        $finish;
    end

endmodule
